@@ src/vtpt_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpt_pkg
// Shared types, constants and helpers for the vertex transform block.
// ----------------------------------------------------------------------------
package vtpt_pkg;

	localparam int VIEWPORT_W = 640;
	localparam int VIEWPORT_H = 480;

	localparam logic signed [31:0] HALF_W = 32'(VIEWPORT_W * 32768);
	localparam logic signed [31:0] HALF_H = 32'(VIEWPORT_H * 32768);

	localparam int REG_N     = 8;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = 6;
	localparam int QUO_W     = 31;
	localparam logic [4:0] ITER_LAST = 5'(QUO_W - 1);

	localparam logic [49:0] ONE_Q = 50'd65536;

	typedef logic [REG_N-1:0][63:0] regs_t;
	typedef logic [15:0][31:0] mat_t;

	// identity matrix
	localparam regs_t REG_RESET = {
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
	};

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROW_INIT,
		S_ROW_MAC,
		S_ROW_LAST,
		S_DIV_START,
		S_DIV_STEP,
		S_DIV_END,
		S_SCR_X,
		S_SCR_Y,
		S_SCR_Z,
		S_COMMIT,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MUL_MAT,
		MUL_HW,
		MUL_HH
	} mul_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic [1:0] row;
		logic [1:0] tap;
		logic       acc_init;
		logic       acc_add;
		logic       row_store;
		logic [1:0] coord;
		logic       div_start;
		logic       div_step;
		logic       div_end;
		logic       scr_x;
		logic       scr_y;
		logic       hold_wr;
		logic       hold_idx;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_special;
		logic tri_drop;
		logic out_empty;
	} sts_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic [16:0]        depth;
		logic [31:0]        color;
		logic               behind;
	} held_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic [16:0]        depth;
		logic [31:0]        color;
		logic               flat;
		logic               last;
	} result_t;

	typedef result_t [2:0] trio_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = 50'sd2147483647;
		lo = -50'sd2147483648;
		if (v > hi) return 32'sh7fff_ffff;
		if (v < lo) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

@@ src/vtpt_regs.sv @@
// ----------------------------------------------------------------------------
// vtpt_regs
// Matrix coefficient registers behind the APB-style port.
// ----------------------------------------------------------------------------
module vtpt_regs import vtpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output mat_t              mat
);

	regs_t reg_q;
	logic [REG_IDX_W-1:0] idx;

	assign idx    = paddr[ADDR_W-1:3];
	assign pready = 1'b1;
	assign prdata = reg_q[idx];
	assign mat    = reg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q <= REG_RESET;
		end else if (psel && penable && pwrite) begin
			reg_q[idx] <= pwdata;
		end
	end

endmodule

@@ src/vtpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vtpt_ctrl
// Sequencer: matrix rows, per-coordinate divide, screen map, triangle slot.
// ----------------------------------------------------------------------------
module vtpt_ctrl import vtpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_nx;
	logic [1:0] row_q;
	logic [1:0] tap_q;
	logic [1:0] coord_q;
	logic [4:0] iter_q;
	logic [1:0] slot_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_nx = S_ROW_INIT;
			S_ROW_INIT:  state_nx = S_ROW_MAC;
			S_ROW_MAC:   if (tap_q == 2'd2) state_nx = S_ROW_LAST;
			S_ROW_LAST:  state_nx = (row_q == 2'd3) ? S_DIV_START : S_ROW_INIT;
			S_DIV_START: begin
				if (!sts.div_special) state_nx = S_DIV_STEP;
				else if (coord_q == 2'd2) state_nx = S_SCR_X;
			end
			S_DIV_STEP:  if (iter_q == ITER_LAST) state_nx = S_DIV_END;
			S_DIV_END:   state_nx = (coord_q == 2'd2) ? S_SCR_X : S_DIV_START;
			S_SCR_X:     state_nx = S_SCR_Y;
			S_SCR_Y:     state_nx = S_SCR_Z;
			S_SCR_Z:     state_nx = S_COMMIT;
			S_COMMIT: begin
				if (!slot_q[1] || sts.tri_drop) state_nx = S_IDLE;
				else state_nx = S_EMIT;
			end
			S_EMIT:      if (sts.out_empty) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_MAT;
		cmd.row      = row_q;
		cmd.tap      = tap_q;
		cmd.coord    = coord_q;
		cmd.hold_idx = slot_q[0];
		in_stall     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			S_ROW_INIT: begin
				cmd.mul_en   = 1'b1;
				cmd.acc_init = 1'b1;
			end
			S_ROW_MAC: begin
				cmd.mul_en  = 1'b1;
				cmd.acc_add = 1'b1;
			end
			S_ROW_LAST:  cmd.row_store = 1'b1;
			S_DIV_START: cmd.div_start = 1'b1;
			S_DIV_STEP:  cmd.div_step  = 1'b1;
			S_DIV_END:   cmd.div_end   = 1'b1;
			S_SCR_X: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HW;
			end
			S_SCR_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HH;
				cmd.scr_x   = 1'b1;
			end
			S_SCR_Z:     cmd.scr_y = 1'b1;
			S_COMMIT:    cmd.hold_wr = !slot_q[1];
			S_EMIT:      cmd.out_load = sts.out_empty;
			default:     in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			tap_q   <= '0;
			coord_q <= '0;
			iter_q  <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_IDLE:     row_q <= '0;
				S_ROW_INIT: tap_q <= 2'd1;
				S_ROW_MAC:  tap_q <= tap_q + 2'd1;
				S_ROW_LAST: begin
					tap_q   <= '0;
					row_q   <= row_q + 2'd1;
					coord_q <= '0;
				end
				S_DIV_START: begin
					iter_q <= '0;
					if (sts.div_special) coord_q <= coord_q + 2'd1;
				end
				S_DIV_STEP: iter_q  <= iter_q + 5'd1;
				S_DIV_END:  coord_q <= coord_q + 2'd1;
				S_COMMIT:   slot_q  <= slot_q[1] ? 2'd0 : slot_q + 2'd1;
				default:    iter_q  <= iter_q;
			endcase
		end
	end

endmodule

@@ src/vtpt_dp.sv @@
// ----------------------------------------------------------------------------
// vtpt_dp
// Datapath: shared multiplier, row accumulator, radix-2 divider, screen map.
// ----------------------------------------------------------------------------
module vtpt_dp import vtpt_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic [31:0]        vertex_color,
	input  mat_t               mat,
	input  cmd_t               cmd,
	output logic               div_special,
	output logic               tri_drop,
	output trio_t              triangle
);

	logic signed [31:0] p_q [3];
	logic [31:0]        color_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [49:0] c_q [4];
	logic signed [31:0] cs_q [3];
	logic [49:0]        den_q;
	logic [49:0]        rem_q;
	logic [30:0]        nsh_q;
	logic [30:0]        quo_q;
	logic               neg_q;
	logic signed [31:0] sx_q;
	logic signed [31:0] sy_q;
	logic [16:0]        dz_q;
	logic               behind_q;
	held_t              held_q [2];

	logic signed [31:0] mul_a, mul_b, trans, sp_val, q_res, dhalf;
	logic signed [65:0] acc_sum;
	logic signed [49:0] n, w, sx_sum, sy_sum;
	logic [49:0]        n_mag, d_mag;
	logic               w_pass, ovf, neg, ge, flat;
	logic [50:0]        trial;
	logic [16:0]        dz;
	logic signed [32:0] zsum;

	always_comb begin
		case (cmd.mul_sel)
			MUL_HW: begin
				mul_a = cs_q[0];
				mul_b = HALF_W;
			end
			MUL_HH: begin
				mul_a = cs_q[1];
				mul_b = HALF_H;
			end
			default: begin
				mul_a = p_q[cmd.tap];
				mul_b = $signed(mat[{cmd.tap, cmd.row}]);
			end
		endcase
	end

	assign trans   = $signed(mat[{2'b11, cmd.row}]);
	assign acc_sum = acc_q + {{2{prod_q[63]}}, prod_q};

	// divide setup: magnitudes, sign and out-of-range test
	assign n      = c_q[cmd.coord];
	assign w      = c_q[3];
	assign n_mag  = n[49] ? 50'(-n) : n;
	assign d_mag  = w[49] ? 50'(-w) : w;
	assign neg    = n[49] ^ w[49];
	assign w_pass = (w == 50'sd0) || (w == $signed(ONE_Q));
	assign ovf    = {15'd0, n_mag} >= {d_mag, 15'd0};
	assign sp_val = w_pass ? sat32(n) : (neg ? 32'sh8000_0000 : 32'sh7fff_ffff);
	assign div_special = w_pass || ovf;

	assign trial = {rem_q, nsh_q[30]};
	assign ge    = trial >= {1'b0, den_q};
	assign q_res = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	assign sx_sum = {{2{prod_q[63]}}, prod_q[63:16]} + {{18{HALF_W[31]}}, HALF_W};
	assign sy_sum = {{18{HALF_H[31]}}, HALF_H} - {{2{prod_q[63]}}, prod_q[63:16]};

	assign zsum  = {cs_q[2][31], cs_q[2]} + 33'sd65536;
	assign dhalf = zsum[32:1];
	always_comb begin
		if (dhalf[31]) dz = '0;
		else if (dhalf > 32'sd65536) dz = 17'd65536;
		else dz = dhalf[16:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			p_q[0]  <= vertex_x;
			p_q[1]  <= vertex_y;
			p_q[2]  <= vertex_z;
			color_q <= vertex_color;
		end
		if (cmd.mul_en) prod_q <= mul_a * mul_b;
		if (cmd.acc_init) acc_q <= {{18{trans[31]}}, trans, 16'd0};
		else if (cmd.acc_add) acc_q <= acc_sum;
		if (cmd.row_store) c_q[cmd.row] <= acc_sum[65:16];
		if (cmd.div_start) begin
			neg_q <= neg;
			den_q <= d_mag;
			rem_q <= {15'd0, n_mag[49:15]};
			nsh_q <= {n_mag[14:0], 16'd0};
			quo_q <= '0;
			if (div_special) cs_q[cmd.coord] <= sp_val;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? 50'(trial - {1'b0, den_q}) : trial[49:0];
			nsh_q <= {nsh_q[29:0], 1'b0};
			quo_q <= {quo_q[29:0], ge};
		end
		if (cmd.div_end) cs_q[cmd.coord] <= q_res;
		if (cmd.scr_x) begin
			sx_q     <= sat32(sx_sum);
			dz_q     <= dz;
			behind_q <= cs_q[2] < -32'sd65536;
		end
		if (cmd.scr_y) sy_q <= sat32(sy_sum);
		if (cmd.hold_wr) held_q[cmd.hold_idx] <= '{sx_q, sy_q, dz_q, color_q, behind_q};
	end

	assign tri_drop = held_q[0].behind && held_q[1].behind && behind_q;
	assign flat     = (held_q[0].color == held_q[1].color) && (held_q[1].color == color_q);

	always_comb begin
		triangle[0] = '{held_q[0].sx, held_q[0].sy, held_q[0].depth, held_q[0].color,
			flat, 1'b0};
		triangle[1] = '{held_q[1].sx, held_q[1].sy, held_q[1].depth, held_q[1].color,
			flat, 1'b0};
		triangle[2] = '{sx_q, sy_q, dz_q, color_q, flat, 1'b1};
	end

endmodule

@@ src/vtpt_outq.sv @@
// ----------------------------------------------------------------------------
// vtpt_outq
// Three-entry result queue, loaded with a whole triangle, drained one a time.
// ----------------------------------------------------------------------------
module vtpt_outq import vtpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  trio_t   triangle,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t head,
	output logic    empty
);

	result_t    ent_q [3];
	logic [1:0] cnt_q;
	logic       xfer;

	assign out_valid = cnt_q != 2'd0;
	assign empty     = cnt_q == 2'd0;
	assign head      = ent_q[0];
	assign xfer      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= 2'd3;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q[0] <= triangle[0];
			ent_q[1] <= triangle[1];
			ent_q[2] <= triangle[2];
		end else if (xfer) begin
			// advance towards the head
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule

@@ src/vertex_transform_project_triangle.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_project_triangle
// Vertex transform, perspective divide and viewport mapping per triangle.
// ----------------------------------------------------------------------------
// One vertex transfer on the input channel (in_valid/in_stall) per vertex.
// Every third vertex closes a triangle: its three results leave on the output
// channel (out_valid/out_stall) in vertex order, the last flagged by
// last_vertex, unless all three vertices lie behind the near plane.
// A vertex runs through the matrix rows on the single 32x32 multiplier, a
// divide per coordinate in the radix-2 divider (skipped when w is 0 or one,
// or when that quotient is out of range), the viewport map and bookkeeping
// before the next vertex is accepted. A triangle's third vertex also hands
// its results to the queue, once it is empty, before the next is accepted.
// Results sit in a three-entry queue; the next vertex is accepted while they
// drain. A stalled receiver holds the head result; the third vertex of the
// next triangle then waits until the queue is empty.
// Reset loads the identity matrix and starts a new triangle. The user makes
// matrix writes through the APB-style port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vertex_transform_project_triangle import vtpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic [31:0]        vertex_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic [16:0]        depth,
	output logic [31:0]        color_out,
	output logic               flat_shaded,
	output logic               last_vertex,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	mat_t    mat;
	cmd_t    cmd;
	sts_t    sts;
	trio_t   triangle;
	result_t head;

	vtpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mat     (mat)
	);

	vtpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vtpt_dp u_dp (
		.clk          (clk),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.vertex_color (vertex_color),
		.mat          (mat),
		.cmd          (cmd),
		.div_special  (sts.div_special),
		.tri_drop     (sts.tri_drop),
		.triangle     (triangle)
	);

	vtpt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.out_load),
		.triangle  (triangle),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.empty     (sts.out_empty)
	);

	assign screen_x    = head.sx;
	assign screen_y    = head.sy;
	assign depth       = head.depth;
	assign color_out   = head.color;
	assign flat_shaded = head.flat;
	assign last_vertex = head.last;

endmodule

@@ src/vtpt_checker.sv @@
// ----------------------------------------------------------------------------
// vtpt_checker
// Port-level checks on the vertex transform block, bound to the top level.
// ----------------------------------------------------------------------------
module vtpt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] screen_x,
	input logic               flat_shaded,
	input logic               last_vertex
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x))
		else $error("stalled result changed");

	// a vertex transfer keeps the input busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// the last result empties the queue
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_vertex |=> !out_valid)
		else $error("result after last vertex");

	// a triangle's results follow one another
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_vertex |=> out_valid)
		else $error("triangle cut short");

	// flat flag is shared by the whole triangle
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_vertex |=> flat_shaded == $past(flat_shaded))
		else $error("flat flag changed within triangle");

endmodule

bind vertex_transform_project_triangle vtpt_checker u_chk (.*);
